FILE: design/blps_pkg.sv
// shared types and constants for the button and led panel scanner
`default_nettype none

package blps_pkg;

    // width of the item kind field
    localparam int KIND_W = 2;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 2'd0,
        KIND_LED_WRITE = 2'd1,
        KIND_CLEAR     = 2'd2
    } t_kind;

    // decoded per-item controls handed to the state unit
    typedef struct packed {
        logic tick;
        logic led_write;
        logic clear;
    } t_step_ctl;

endpackage

`default_nettype wire

FILE: design/blps_debounce.sv
// two-bit vertical counter debouncer, one counter per button
`default_nettype none

module blps_debounce #(
    parameter int BUTTON_COUNT = 5
) (
    input  wire logic [BUTTON_COUNT-1:0] i_level,
    input  wire logic [BUTTON_COUNT-1:0] i_cnt_lo,
    input  wire logic [BUTTON_COUNT-1:0] i_cnt_hi,
    input  wire logic [BUTTON_COUNT-1:0] i_pressed,
    output logic      [BUTTON_COUNT-1:0] o_level,
    output logic      [BUTTON_COUNT-1:0] o_cnt_lo,
    output logic      [BUTTON_COUNT-1:0] o_cnt_hi,
    output logic      [BUTTON_COUNT-1:0] o_rise
);

    logic [BUTTON_COUNT-1:0] diff;
    logic [BUTTON_COUNT-1:0] flip;

    // buttons that disagree with their debounced level keep counting
    assign diff     = i_level ^ i_pressed;
    assign o_cnt_lo = ~(i_cnt_lo & diff);
    assign o_cnt_hi = o_cnt_lo ^ (i_cnt_hi & diff);

    // a counter that wraps flips the debounced level
    assign flip    = diff & o_cnt_lo & o_cnt_hi;
    assign o_level = i_level ^ flip;
    assign o_rise  = o_level & flip;

endmodule

`default_nettype wire

FILE: design/blps_state.sv
// panel state: led pattern, scan position, debouncer and sticky press status
`default_nettype none

module blps_state #(
    parameter int LED_COUNT    = 8,
    parameter int BUTTON_COUNT = 5,
    parameter int DATA_W       = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire blps_pkg::t_step_ctl      i_ctl,
    input  wire logic [BUTTON_COUNT-1:0]  i_pins,
    input  wire logic [DATA_W-1:0]        i_data,
    output logic      [LED_COUNT-1:0]     o_drive,
    output logic      [BUTTON_COUNT-1:0]  o_status,
    output logic      [LED_COUNT-1:0]     o_led
);

    localparam int POS_W = $clog2(LED_COUNT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LED_COUNT - 1);

    logic [LED_COUNT-1:0]    r_pattern;
    logic [POS_W-1:0]        r_pos;
    logic                    r_phase;
    logic [BUTTON_COUNT-1:0] r_level;
    logic [BUTTON_COUNT-1:0] r_cnt_lo;
    logic [BUTTON_COUNT-1:0] r_cnt_hi;
    logic [BUTTON_COUNT-1:0] r_sticky;

    logic [LED_COUNT-1:0]    n_pattern;
    logic [POS_W-1:0]        n_pos;
    logic                    n_phase;
    logic [BUTTON_COUNT-1:0] n_level;
    logic [BUTTON_COUNT-1:0] n_cnt_lo;
    logic [BUTTON_COUNT-1:0] n_cnt_hi;
    logic [BUTTON_COUNT-1:0] n_sticky;

    logic [BUTTON_COUNT-1:0] db_level;
    logic [BUTTON_COUNT-1:0] db_cnt_lo;
    logic [BUTTON_COUNT-1:0] db_cnt_hi;
    logic [BUTTON_COUNT-1:0] db_rise;
    logic [LED_COUNT-1:0]    scan_bit;

    // debouncer on the active-high pressed levels
    blps_debounce #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_debounce (
        .i_level   (r_level),
        .i_cnt_lo  (r_cnt_lo),
        .i_cnt_hi  (r_cnt_hi),
        .i_pressed (~i_pins),
        .o_level   (db_level),
        .o_cnt_lo  (db_cnt_lo),
        .o_cnt_hi  (db_cnt_hi),
        .o_rise    (db_rise)
    );

    // one-hot select of the led at the current scan position
    assign scan_bit = {{(LED_COUNT-1){1'b0}}, 1'b1} << r_pos;

    // next state for the item in hand
    always_comb begin
        n_pattern = r_pattern;
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_level   = r_level;
        n_cnt_lo  = r_cnt_lo;
        n_cnt_hi  = r_cnt_hi;
        n_sticky  = r_sticky;
        o_drive   = '0;
        if (i_ctl.tick) begin
            o_drive = r_pattern & scan_bit;
            n_pos   = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            n_phase = ~r_phase;
            // buttons sampled on every second tick
            if (r_phase) begin
                n_level  = db_level;
                n_cnt_lo = db_cnt_lo;
                n_cnt_hi = db_cnt_hi;
                n_sticky = r_sticky | db_rise;
            end
        end else if (i_ctl.led_write) begin
            n_pattern = i_data[LED_COUNT-1:0];
        end else if (i_ctl.clear) begin
            n_sticky = r_sticky & ~i_data[BUTTON_COUNT-1:0];
        end
    end

    // results show the state after the item
    assign o_status = n_sticky;
    assign o_led    = n_pattern;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_pos     <= '0;
            r_phase   <= 1'b0;
            r_level   <= '0;
            r_cnt_lo  <= '1;
            r_cnt_hi  <= '1;
            r_sticky  <= '0;
        end else if (i_en) begin
            r_pattern <= n_pattern;
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_level   <= n_level;
            r_cnt_lo  <= n_cnt_lo;
            r_cnt_hi  <= n_cnt_hi;
            r_sticky  <= n_sticky;
        end
    end

`ifndef ASSERT_OFF
    // new press bits appear only on a tick
    a_sticky_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_en && i_ctl.tick) |=> ((r_sticky & ~$past(r_sticky)) == '0))
        else $error("sticky press bit set outside a tick");

    // scan position stays in range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("scan position out of range");

    // scan position moves only on a tick
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_en && i_ctl.tick) |=> $stable(r_pos))
        else $error("scan position moved without a tick");

    // debouncer state changes only on sampling ticks
    a_db_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_en && i_ctl.tick && r_phase) |=> ($stable(r_level) && $stable(r_cnt_lo)))
        else $error("debouncer changed off a sampling tick");
`endif

endmodule

`default_nettype wire

FILE: design/button_led_panel_scanner.sv
// top level of the button and led panel scanner
`default_nettype none

// Each transfer on the input channel is a scan tick, an led pattern write or a
// write-one-to-clear of the button status, and gives exactly one result
// transfer. An item is taken into an input register, worked on against the
// panel state, and its result lands in an output register, so the block
// sustains one item per clock while the output side does not stall. Input
// stall rises only when both registers are full and the output side stalls.
// The led drive shows the pattern bit at the scan position in force before
// the tick; buttons are active low and sampled on every second tick, a press
// becoming stable after four matching samples. The interrupt output is high
// while any status bit is set.
module button_led_panel_scanner #(
    parameter int LED_COUNT    = 8,
    parameter int BUTTON_COUNT = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [blps_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [BUTTON_COUNT-1:0]           i_button_pins,
    input  wire logic [((LED_COUNT > BUTTON_COUNT) ? LED_COUNT : BUTTON_COUNT)-1:0]
                                                   i_write_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [LED_COUNT-1:0]              o_led_drive,
    output logic      [BUTTON_COUNT-1:0]           o_button_status,
    output logic      [LED_COUNT-1:0]              o_led_register,
    output logic                                   o_host_irq
);

    localparam int DATA_W = (LED_COUNT > BUTTON_COUNT) ? LED_COUNT : BUTTON_COUNT;

    logic                          r_in_valid;
    logic [blps_pkg::KIND_W-1:0]   r_kind;
    logic [BUTTON_COUNT-1:0]       r_pins;
    logic [DATA_W-1:0]             r_data;

    logic                          r_out_valid;
    logic [LED_COUNT-1:0]          r_led_drive;
    logic [BUTTON_COUNT-1:0]       r_status;
    logic [LED_COUNT-1:0]          r_led_reg;

    logic                          out_load;
    logic                          in_load;
    logic                          work_en;
    blps_pkg::t_step_ctl           step_ctl;
    logic [LED_COUNT-1:0]          res_drive;
    logic [BUTTON_COUNT-1:0]       res_status;
    logic [LED_COUNT-1:0]          res_led;

    // pipeline flow control
    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign work_en    = r_in_valid && out_load;
    assign o_in_stall = !in_load;

    // decode the item kind
    always_comb begin
        step_ctl = '0;
        case (blps_pkg::t_kind'(r_kind))
            blps_pkg::KIND_TICK:      step_ctl.tick      = 1'b1;
            blps_pkg::KIND_LED_WRITE: step_ctl.led_write = 1'b1;
            blps_pkg::KIND_CLEAR:     step_ctl.clear     = 1'b1;
            default:                  step_ctl           = '0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_kind <= i_kind;
            r_pins <= i_button_pins;
            r_data <= i_write_data;
        end
    end

    blps_state #(
        .LED_COUNT    (LED_COUNT),
        .BUTTON_COUNT (BUTTON_COUNT),
        .DATA_W       (DATA_W)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (work_en),
        .i_ctl    (step_ctl),
        .i_pins   (r_pins),
        .i_data   (r_data),
        .o_drive  (res_drive),
        .o_status (res_status),
        .o_led    (res_led)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_en) begin
            r_led_drive <= res_drive;
            r_status    <= res_status;
            r_led_reg   <= res_led;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_led_drive     = r_led_drive;
    assign o_button_status = r_status;
    assign o_led_register  = r_led_reg;
    assign o_host_irq      = |r_status;

`ifndef ASSERT_OFF
    // a full pipeline with a stalled output holds off new input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline full and output stalled");

    // a held result is not overwritten
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_status)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_button_led_panel_scanner.sv
// testbench for the button and led panel scanner: directed panel cases then random traffic
`timescale 1ns / 100ps

module tb_button_led_panel_scanner;

    localparam int LEDS        = 8;
    localparam int BUTTONS     = 5;
    localparam int DATA_W      = (LEDS > BUTTONS) ? LEDS : BUTTONS;
    localparam int QUIET_LIMIT = 3000;

    // the one kind code the package leaves unnamed
    localparam logic [blps_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [LEDS-1:0]    led_drive;
        logic [BUTTONS-1:0] button_status;
        logic [LEDS-1:0]    led_register;
        logic               host_irq;
    } t_panel_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_stall;
    logic [blps_pkg::KIND_W-1:0]   i_kind        = blps_pkg::KIND_TICK;
    logic [BUTTONS-1:0]            i_button_pins = '1;
    logic [DATA_W-1:0]             i_write_data  = '0;
    logic                          o_out_valid;
    logic                          i_out_stall   = 1'b0;
    logic [LEDS-1:0]               o_led_drive;
    logic [BUTTONS-1:0]            o_button_status;
    logic [LEDS-1:0]               o_led_register;
    logic                          o_host_irq;

    // panel state as the block should hold it
    logic [LEDS-1:0]      pattern_r   = '0;
    logic [2:0]           scan_idx    = '0;
    logic                 sample_now  = 1'b0;
    logic [BUTTONS-1:0]   stable_lvl  = '0;
    logic [BUTTONS-1:0]   vc_low      = '1;
    logic [BUTTONS-1:0]   vc_high     = '1;
    logic [BUTTONS-1:0]   press_flags = '0;

    t_panel_result        expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int presses_seen   = 0;
    int kind_sent[4]   = '{0, 0, 0, 0};

    button_led_panel_scanner #(
        .LED_COUNT    (LEDS),
        .BUTTON_COUNT (BUTTONS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_button_pins   (i_button_pins),
        .i_write_data    (i_write_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_led_drive     (o_led_drive),
        .o_button_status (o_button_status),
        .o_led_register  (o_led_register),
        .o_host_irq      (o_host_irq)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // advance the panel state by one item and queue the result it gives
    function automatic void predict_panel_step(input logic [blps_pkg::KIND_W-1:0] kind,
                                               input logic [BUTTONS-1:0] pins,
                                               input logic [DATA_W-1:0] data);
        t_panel_result      res;
        logic [BUTTONS-1:0] change;
        logic [BUTTONS-1:0] newly_pressed;
        res.led_drive = '0;
        case (kind)
            blps_pkg::KIND_TICK: begin
                res.led_drive[scan_idx] = pattern_r[scan_idx];
                scan_idx = scan_idx + 3'd1;
                if (sample_now) begin
                    // two-bit vertical counter, pins are active low
                    change        = stable_lvl ^ ~pins;
                    vc_low        = ~(vc_low & change);
                    vc_high       = vc_low ^ (vc_high & change);
                    change        = change & vc_low & vc_high;
                    stable_lvl    = stable_lvl ^ change;
                    newly_pressed = stable_lvl & change;
                    press_flags   = press_flags | newly_pressed;
                    presses_seen  += $countones(newly_pressed);
                end
                sample_now = ~sample_now;
            end
            blps_pkg::KIND_LED_WRITE: pattern_r = data[LEDS-1:0];
            blps_pkg::KIND_CLEAR:     press_flags = press_flags & ~data[BUTTONS-1:0];
            default: ;
        endcase
        res.button_status = press_flags;
        res.led_register  = pattern_r;
        res.host_irq      = |press_flags;
        expected_results.push_back(res);
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_panel_item(input logic [blps_pkg::KIND_W-1:0] kind,
                                   input logic [BUTTONS-1:0] pins,
                                   input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_button_pins <= pins;
        i_write_data  <= data;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_panel_step(kind, pins, data);
        kind_sent[kind]++;
    endtask

    // hold off the sender until every result is back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // receiver stall and result checking
    always @(posedge i_clk) begin
        t_panel_result want;
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation pending");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("led_drive", 8'(want.led_drive), 8'(o_led_drive));
                check_field("button_status", 8'(want.button_status), 8'(o_button_status));
                check_field("led_register", 8'(want.led_register), 8'(o_led_register));
                check_field("host_irq", 8'(want.host_irq), 8'(o_host_irq));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $error("no transfer for %0d cycles", QUIET_LIMIT);
        $display("button_led_panel_scanner regression: fail");
        $finish;
    end

    // unused kind changes nothing, with every pin and data bit at both levels
    task automatic test_unused_kind();
        send_panel_item(KIND_UNUSED, '1, '1);
        send_panel_item(KIND_UNUSED, '0, '0);
    endtask

    // all buttons held for four samples become stable presses
    task automatic test_stable_press();
        send_panel_item(blps_pkg::KIND_LED_WRITE, '1, 8'hff);
        repeat (8) send_panel_item(blps_pkg::KIND_TICK, '0, '0);
    endtask

    // clear mask bits above the buttons do nothing, then clear buttons 0 and 2, then everything
    task automatic test_status_clear();
        send_panel_item(blps_pkg::KIND_CLEAR, '0, 8'he0);
        send_panel_item(blps_pkg::KIND_CLEAR, '1, 8'h05);
        send_panel_item(blps_pkg::KIND_CLEAR, '0, 8'hff);
    endtask

    // release stabilizes without setting status
    task automatic test_stable_release();
        send_panel_item(blps_pkg::KIND_LED_WRITE, '0, 8'h00);
        repeat (8) send_panel_item(blps_pkg::KIND_TICK, '1, 8'hff);
        send_panel_item(blps_pkg::KIND_LED_WRITE, '1, 8'ha5);
    endtask

    // mostly ticks with held button levels, some bounce, writes, clears and unused kinds
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        logic [BUTTONS-1:0]          held;
        logic [BUTTONS-1:0]          pins;
        logic [DATA_W-1:0]           data;
        logic [blps_pkg::KIND_W-1:0] kind;
        int                          pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        held = BUTTONS'($urandom);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            pins = BUTTONS'($urandom);
            data = DATA_W'($urandom);
            if (pick < 72) begin
                kind = blps_pkg::KIND_TICK;
                if ($urandom_range(99) < 6)
                    held = BUTTONS'($urandom);
                if ($urandom_range(99) >= 8)
                    pins = held;
            end else if (pick < 84) begin
                kind = blps_pkg::KIND_LED_WRITE;
            end else if (pick < 96) begin
                kind = blps_pkg::KIND_CLEAR;
                if ($urandom_range(99) < 30)
                    data = '1;
            end else begin
                kind = KIND_UNUSED;
            end
            send_panel_item(kind, pins, data);
        end
    endtask

    initial begin
        send_idle_pct  = 19;
        recv_stall_pct = 84;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unused_kind();
        test_stable_press();
        test_status_clear();
        test_stable_release();

        test_random_traffic(19, 84, 450);
        wait_for_drain();
        test_random_traffic(84, 19, 450);
        wait_for_drain();
        test_random_traffic(0, 0, 450);

        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d ticks, %0d led writes, %0d status clears, %0d unused kinds",
                 kind_sent[blps_pkg::KIND_TICK], kind_sent[blps_pkg::KIND_LED_WRITE],
                 kind_sent[blps_pkg::KIND_CLEAR], kind_sent[KIND_UNUSED]);
        $display("%0d results checked, %0d debounced presses, %0d mismatches",
                 results_seen, presses_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("button_led_panel_scanner regression: pass");
        else
            $display("button_led_panel_scanner regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
design/blps_pkg.sv
design/blps_debounce.sv
design/blps_state.sv
design/button_led_panel_scanner.sv
sim/tb_button_led_panel_scanner.sv
